// ===== src/atab2t_pkg.sv =====
// Shared widths, register indexes and task-file byte constants for the block-to-taskfile unit.
package atab2t_pkg;

	localparam int BLOCK_W = 28;	// width of the block number port
	localparam int HC_W    = 5;	// head count register width
	localparam int SPT_W   = 8;	// sectors per track register width
	localparam int PC_W    = HC_W + SPT_W;	// sectors per cylinder width
	localparam int HEAD_W  = HC_W;	// head index out of the second divider

	localparam logic [HC_W-1:0] MAX_HEADS = 5'd16;

	localparam logic [7:0] DH_LBA_BASE = 8'he0;
	localparam logic [7:0] DH_CHS_BASE = 8'ha0;
	localparam logic [7:0] DH_SLAVE    = 8'h10;
	localparam logic [7:0] CMD_READ    = 8'h20;
	localparam logic [7:0] CMD_WRITE   = 8'h30;

	typedef enum logic [1:0] {
		REG_LBA_MODE    = 2'd0,
		REG_DRIVE_SLAVE = 2'd1,
		REG_HEAD_COUNT  = 2'd2,
		REG_SPT         = 2'd3
	} cfg_reg_t;

endpackage

// ===== src/atab2t_div_cell.sv =====
// One restoring-division step cell: takes one dividend bit, emits one quotient bit.
module atab2t_div_cell #(
	parameter int RW = 13,
	parameter int XW = 28,
	parameter int SW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          up_valid,
	input  logic [RW-1:0] up_rem,
	input  logic [XW-1:0] up_x,
	input  logic [SW-1:0] up_side,
	input  logic [RW-1:0] divisor,
	output logic          dn_valid,
	output logic [RW-1:0] dn_rem,
	output logic [XW-1:0] dn_x,
	output logic [SW-1:0] dn_side
);

	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;
	logic [RW-1:0] rem_n;
	logic [XW-1:0] x_n;
	logic          valid_q;
	logic [RW-1:0] rem_q;
	logic [XW-1:0] x_q;
	logic [SW-1:0] side_q;

	// x shifts dividend bits out the top and quotient bits in at the bottom
	always_comb begin
		trial = {up_rem, up_x[XW-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
		rem_n = ge ? diff[RW-1:0] : trial[RW-1:0];
		x_n   = {up_x[XW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			x_q    <= x_n;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_x     = x_q;
	assign dn_side  = side_q;

endmodule

// ===== src/atab2t_div_chain.sv =====
// Row of division step cells giving quotient and remainder of an XW-bit dividend.
module atab2t_div_chain #(
	parameter int RW = 13,
	parameter int XW = 28,
	parameter int SW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          up_valid,
	input  logic [RW-1:0] up_rem,
	input  logic [XW-1:0] up_x,
	input  logic [SW-1:0] up_side,
	input  logic [RW-1:0] divisor,
	output logic          dn_valid,
	output logic [RW-1:0] dn_rem,
	output logic [XW-1:0] dn_x,
	output logic [SW-1:0] dn_side
);

	logic          valid_w [0:XW];
	logic [RW-1:0] rem_w   [0:XW];
	logic [XW-1:0] x_w     [0:XW];
	logic [SW-1:0] side_w  [0:XW];

	assign valid_w[0] = up_valid;
	assign rem_w[0]   = up_rem;
	assign x_w[0]     = up_x;
	assign side_w[0]  = up_side;

	for (genvar i = 0; i < XW; i++) begin : g_cell
		atab2t_div_cell #(
			.RW(RW),
			.XW(XW),
			.SW(SW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.up_valid(valid_w[i]),
			.up_rem  (rem_w[i]),
			.up_x    (x_w[i]),
			.up_side (side_w[i]),
			.divisor (divisor),
			.dn_valid(valid_w[i+1]),
			.dn_rem  (rem_w[i+1]),
			.dn_x    (x_w[i+1]),
			.dn_side (side_w[i+1])
		);
	end

	assign dn_valid = valid_w[XW];
	assign dn_rem   = rem_w[XW];
	assign dn_x     = x_w[XW];
	assign dn_side  = side_w[XW];

endmodule

// ===== src/ata_block_to_taskfile_unit.sv =====
// Top level: block number to ATA task-file bytes, LBA or CHS, one item per cycle.
// Path from accepted item to result valid:
// one cell per quotient bit of block / (heads * sectors), five cells for the head
// index, then the output register. Throughput is one item per cycle; the whole row
// of cells holds only while the output register keeps a stalled result.
// Reset clears all valid bits and loads lba_mode=1, drive_slave=0, 16 heads, 63 sectors.
module ata_block_to_taskfile_unit #(
	parameter int BLOCK_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [atab2t_pkg::BLOCK_W-1:0] block_number,
	input  logic                          is_write,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [7:0]                    sector_number,
	output logic [7:0]                    cylinder_low,
	output logic [7:0]                    cylinder_high,
	output logic [7:0]                    drive_head,
	output logic [7:0]                    command_code,
	output logic                          out_of_range
);

	import atab2t_pkg::*;

	localparam int SWA = BLOCK_BITS + 1;
	localparam int SWB = 2 * BLOCK_BITS + 1;

	logic              lba_mode_q;
	logic              drive_slave_q;
	logic [HC_W-1:0]   head_count_q;
	logic [SPT_W-1:0]  spt_q;
	logic [PC_W-1:0]   per_cyl;
	logic              en;

	logic              a_valid;
	logic [PC_W-1:0]   a_rem;
	logic [BLOCK_BITS-1:0] a_x;
	logic [SWA-1:0]    a_side;

	logic              b_valid;
	logic [SPT_W-1:0]  b_rem;
	logic [HEAD_W-1:0] b_x;
	logic [SWB-1:0]    b_side;

	logic [BLOCK_W-1:0] blk_ext;
	logic [BLOCK_W-1:0] cyl_ext;
	logic              wr;
	logic [7:0]        sel;
	logic [7:0]        sect_n;
	logic [7:0]        cyl_lo_n;
	logic [7:0]        cyl_hi_n;
	logic [7:0]        dh_n;
	logic              oor_n;

	logic              valid_q;
	logic [7:0]        sect_q;
	logic [7:0]        cyl_lo_q;
	logic [7:0]        cyl_hi_q;
	logic [7:0]        dh_q;
	logic [7:0]        cmd_q;
	logic              oor_q;

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lba_mode_q    <= 1'b1;
			drive_slave_q <= 1'b0;
			head_count_q  <= MAX_HEADS;
			spt_q         <= 8'd63;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LBA_MODE:    lba_mode_q    <= cfg_data[0];
				REG_DRIVE_SLAVE: drive_slave_q <= cfg_data[0];
				REG_HEAD_COUNT:  head_count_q  <= cfg_data[HC_W-1:0];
				REG_SPT:         spt_q         <= cfg_data[SPT_W-1:0];
			endcase
		end
	end

	assign per_cyl = PC_W'(head_count_q) * PC_W'(spt_q);

	// the row only holds when a finished result is stalled
	assign item_stall = valid_q && result_stall;
	assign en         = !item_stall;

	// block / sectors-per-cylinder
	atab2t_div_chain #(
		.RW(PC_W),
		.XW(BLOCK_BITS),
		.SW(SWA)
	) u_cyl_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.up_valid(item_valid),
		.up_rem  ('0),
		.up_x    (block_number[BLOCK_BITS-1:0]),
		.up_side ({is_write, block_number[BLOCK_BITS-1:0]}),
		.divisor (per_cyl),
		.dn_valid(a_valid),
		.dn_rem  (a_rem),
		.dn_x    (a_x),
		.dn_side (a_side)
	);

	// remainder / sectors-per-track; the quotient is below 32, so the top
	// bits of the remainder already sit below the divisor
	atab2t_div_chain #(
		.RW(SPT_W),
		.XW(HEAD_W),
		.SW(SWB)
	) u_head_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.up_valid(a_valid),
		.up_rem  (a_rem[PC_W-1:HEAD_W]),
		.up_x    (a_rem[HEAD_W-1:0]),
		.up_side ({a_side, a_x}),
		.divisor (spt_q),
		.dn_valid(b_valid),
		.dn_rem  (b_rem),
		.dn_x    (b_x),
		.dn_side (b_side)
	);

	always_comb begin
		wr      = b_side[SWB-1];
		blk_ext = BLOCK_W'(b_side[2*BLOCK_BITS-1:BLOCK_BITS]);
		cyl_ext = BLOCK_W'(b_side[BLOCK_BITS-1:0]);
		sel     = drive_slave_q ? DH_SLAVE : 8'h00;
		if (lba_mode_q) begin
			sect_n   = blk_ext[7:0];
			cyl_lo_n = blk_ext[15:8];
			cyl_hi_n = blk_ext[23:16];
			dh_n     = DH_LBA_BASE | sel | {4'h0, blk_ext[27:24]};
			oor_n    = 1'b0;
		end else if (head_count_q == '0 || spt_q == '0) begin
			sect_n   = 8'h00;
			cyl_lo_n = 8'h00;
			cyl_hi_n = 8'h00;
			dh_n     = DH_CHS_BASE | sel;
			oor_n    = 1'b1;
		end else begin
			sect_n   = b_rem + 8'd1;
			cyl_lo_n = cyl_ext[7:0];
			cyl_hi_n = cyl_ext[15:8];
			dh_n     = DH_CHS_BASE | sel | {4'h0, b_x[3:0]};
			oor_n    = (|cyl_ext[BLOCK_W-1:16]) || (head_count_q > MAX_HEADS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sect_q   <= sect_n;
			cyl_lo_q <= cyl_lo_n;
			cyl_hi_q <= cyl_hi_n;
			dh_q     <= dh_n;
			cmd_q    <= wr ? CMD_WRITE : CMD_READ;
			oor_q    <= oor_n;
		end
	end

	assign result_valid  = valid_q;
	assign sector_number = sect_q;
	assign cylinder_low  = cyl_lo_q;
	assign cylinder_high = cyl_hi_q;
	assign drive_head    = dh_q;
	assign command_code  = cmd_q;
	assign out_of_range  = oor_q;

endmodule
